// File: hdl/kmp_pkg.sv
`default_nettype none
package kmp_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int SYM_W = 8;
  localparam int POS_W = 32;
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_FALL,
    S_TAIL,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [SYM_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } sym_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [LEN_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } pfx_req_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] index;
  } emit_t;

endpackage
`default_nettype wire

// File: hdl/kmp_ram.sv
`default_nettype none
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: hdl/kmp_ctrl.sv
`default_nettype none
module kmp_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      op_i,
  input  wire logic [kmp_pkg::SYM_W-1:0] symbol_i,
  input  wire logic                      first_i,
  output logic                           busy_o,
  output kmp_pkg::sym_req_t              sym_req_o,
  input  wire logic [kmp_pkg::SYM_W-1:0] sym_rdata_i,
  output kmp_pkg::pfx_req_t              pfx_req_o,
  input  wire logic [kmp_pkg::LEN_W-1:0] pfx_rdata_i,
  input  wire logic                      emit_free_i,
  output kmp_pkg::emit_t                 emit_o
);
  import kmp_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  state_e           state_q, state_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] build_q, build_d;
  logic [LEN_W-1:0] matched_q, matched_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] tpos_q, tpos_d;
  logic [POS_W-1:0] mi_q, mi_d;
  logic [LEN_W-1:0] cur_q, cur_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             text_q, text_d;

  logic [LEN_W-1:0] eff_count, eff_build, eff_matched, nl;
  logic [POS_W-1:0] eff_pos;
  logic             eq, lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      build_q   <= '0;
      matched_q <= '0;
      pos_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      build_q   <= build_d;
      matched_q <= matched_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tpos_q <= tpos_d;
    mi_q   <= mi_d;
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    sym_q  <= sym_d;
    text_q <= text_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    build_d   = build_q;
    matched_d = matched_q;
    pos_d     = pos_q;
    tpos_d    = tpos_q;
    mi_d      = mi_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    sym_d     = sym_q;
    text_d    = text_q;
    sym_req_o = '0;
    pfx_req_o = '0;
    emit_o    = '0;
    busy_o    = (state_q != S_IDLE);

    eff_count   = first_i ? '0 : count_q;
    eff_build   = first_i ? '0 : build_q;
    eff_matched = first_i ? '0 : matched_q;
    eff_pos     = first_i ? '0 : pos_q;

    eq  = (sym_rdata_i == sym_q);
    lim = (cur_q < idx_q);
    nl  = (eq && (text_q || lim)) ? cur_q + LEN_W'(1) : cur_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sym_d  = symbol_i;
          text_d = op_i;
          if (op_i == OP_PATTERN) begin
            if (first_i) begin
              count_d   = '0;
              build_d   = '0;
              matched_d = '0;
            end
            if (eff_count < MAX_LEN) begin
              sym_req_o.we    = 1'b1;
              sym_req_o.waddr = eff_count[IDX_W-1:0];
              sym_req_o.wdata = symbol_i;
              idx_d           = eff_count;
              if (eff_count == '0) begin
                pfx_req_o.we    = 1'b1;
                pfx_req_o.waddr = '0;
                pfx_req_o.wdata = '0;
                build_d         = '0;
                count_d         = LEN_W'(1);
              end else begin
                cur_d   = eff_build;
                state_d = S_FETCH;
              end
            end
          end else begin
            tpos_d    = eff_pos;
            pos_d     = (eff_pos == POS_MAX) ? eff_pos : eff_pos + POS_W'(1);
            matched_d = eff_matched;
            if (count_q != '0) begin
              cur_d   = (eff_matched >= count_q) ? '0 : eff_matched;
              state_d = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        sym_req_o.re    = 1'b1;
        sym_req_o.raddr = cur_q[IDX_W-1:0];
        state_d         = S_CMP;
      end
      S_CMP: begin
        if (cur_q != '0 && !eq && (text_q || lim)) begin
          pfx_req_o.re    = 1'b1;
          pfx_req_o.raddr = cur_q[IDX_W-1:0] - IDX_W'(1);
          state_d         = S_FALL;
        end else if (!text_q) begin
          pfx_req_o.we    = 1'b1;
          pfx_req_o.waddr = idx_q[IDX_W-1:0];
          pfx_req_o.wdata = nl;
          build_d         = nl;
          count_d         = idx_q + LEN_W'(1);
          state_d         = S_IDLE;
        end else if (nl == count_q) begin
          mi_d            = tpos_q - POS_W'(count_q - LEN_W'(1));
          pfx_req_o.re    = 1'b1;
          pfx_req_o.raddr = count_q[IDX_W-1:0] - IDX_W'(1);
          state_d         = S_TAIL;
        end else begin
          matched_d = nl;
          state_d   = S_IDLE;
        end
      end
      S_FALL: begin
        cur_d           = pfx_rdata_i;
        sym_req_o.re    = 1'b1;
        sym_req_o.raddr = pfx_rdata_i[IDX_W-1:0];
        state_d         = S_CMP;
      end
      S_TAIL: begin
        matched_d = pfx_rdata_i;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (emit_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.index = mi_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/kmp_stream_pattern_matcher_unit.sv
// Sequencing: a pattern byte stays idle when it is the first, restarts to an empty pattern or
// overflows, else it goes through fetch and compare, plus fallback and compare per failure link;
// a text byte stays idle with no pattern, else likewise, then tail and emit on a match.
// Throughput: one byte at a time; each fallback costs a prefix-table read and a store read;
// a match also holds in the emit state for every cycle the output beat stays stalled.
// Reset: rst_ni clears counts, matcher and position; store and table hold junk until loaded.
`default_nettype none
module kmp_stream_pattern_matcher_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      op_i,
  input  wire logic [kmp_pkg::SYM_W-1:0] symbol_i,
  input  wire logic                      first_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [kmp_pkg::POS_W-1:0] match_index_o
);
  import kmp_pkg::*;

  sym_req_t         sym_req;
  pfx_req_t         pfx_req;
  emit_t            emit;
  logic [SYM_W-1:0] sym_rdata;
  logic [LEN_W-1:0] pfx_rdata;
  logic             busy;
  logic             out_valid_q;
  logic [POS_W-1:0] out_index_q;
  logic             emit_free;

  assign in_stall_o    = busy;
  assign out_valid_o   = out_valid_q;
  assign match_index_o = out_index_q;
  assign emit_free     = !out_valid_q || !out_stall_i;

  kmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .op_i        (op_i),
    .symbol_i    (symbol_i),
    .first_i     (first_i),
    .busy_o      (busy),
    .sym_req_o   (sym_req),
    .sym_rdata_i (sym_rdata),
    .pfx_req_o   (pfx_req),
    .pfx_rdata_i (pfx_rdata),
    .emit_free_i (emit_free),
    .emit_o      (emit)
  );

  kmp_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_PATTERN),
    .AW    (IDX_W)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_req.we),
    .waddr_i (sym_req.waddr),
    .wdata_i (sym_req.wdata),
    .re_i    (sym_req.re),
    .raddr_i (sym_req.raddr),
    .rdata_o (sym_rdata)
  );

  kmp_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_PATTERN),
    .AW    (IDX_W)
  ) u_pfx_ram (
    .clk_i   (clk_i),
    .we_i    (pfx_req.we),
    .waddr_i (pfx_req.waddr),
    .wdata_i (pfx_req.wdata),
    .re_i    (pfx_req.re),
    .raddr_i (pfx_req.raddr),
    .rdata_o (pfx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_index_q <= emit.index;
    end
  end

endmodule
`default_nettype wire

// File: verif/kmp_stream_pattern_matcher_unit_tb.sv
`timescale 1ns / 100ps
module kmp_stream_pattern_matcher_unit_tb;
  import kmp_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int BEAT_TARGET = 1250;
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 1000000;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic             op_i          = OP_PATTERN;
  logic [SYM_W-1:0] symbol_i      = '0;
  logic             first_i       = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [POS_W-1:0] match_index_o;

  logic             idle_en       = 1'b1;
  int               beats_sent    = 0;
  int               fail_count    = 0;
  int               cycle_count   = 0;

  // matcher shadow state
  logic [SYM_W-1:0] pat_sym [MAX_PATTERN];
  logic [LEN_W-1:0] pat_pfx [MAX_PATTERN];
  logic [LEN_W-1:0] pat_len  = '0;
  logic [LEN_W-1:0] pfx_len  = '0;
  logic [LEN_W-1:0] hit_len  = '0;
  logic [POS_W-1:0] text_pos = '0;
  logic [POS_W-1:0] match_index_q [$];
  logic [POS_W-1:0] expected_index;

  kmp_stream_pattern_matcher_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .symbol_i      (symbol_i),
    .first_i       (first_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_index_o (match_index_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (match_index_q.size() == 0) begin
        $error("match_index: expected none, actual %0h", match_index_o);
        fail_count++;
      end else begin
        expected_index = match_index_q.pop_front();
        if (match_index_o !== expected_index) begin
          $error("match_index: expected %0h, actual %0h", expected_index, match_index_o);
          fail_count++;
        end
      end
    end
  end

  function automatic void track_beat(input logic op, input logic [SYM_W-1:0] sym,
                                     input logic restart);
    int               idx;
    int               len;
    int               j;
    logic [POS_W-1:0] pos;
    if (op == OP_PATTERN) begin
      if (restart) begin
        pat_len = '0;
        pfx_len = '0;
        hit_len = '0;
      end
      if (pat_len < MAX_PATTERN) begin
        idx = int'(pat_len);
        pat_sym[idx] = sym;
        if (idx == 0) begin
          len = 0;
        end else begin
          len = int'(pfx_len);
          while (len > 0 && len < idx && pat_sym[len] != sym) len = int'(pat_pfx[len-1]);
          if (len < idx && pat_sym[len] == sym) len++;
        end
        pat_pfx[idx] = LEN_W'(len);
        pfx_len = LEN_W'(len);
        pat_len = LEN_W'(idx + 1);
      end
    end else begin
      if (restart) begin
        text_pos = '0;
        hit_len  = '0;
      end
      pos = text_pos;
      if (text_pos != '1) text_pos = text_pos + 1;
      if (pat_len != 0) begin
        j = int'(hit_len);
        if (j >= pat_len) j = 0;
        while (j > 0 && pat_sym[j] != sym) j = int'(pat_pfx[j-1]);
        if (pat_sym[j] == sym) j++;
        if (j == pat_len) begin
          match_index_q.push_back(pos - POS_W'(pat_len) + POS_W'(1));
          j = int'(pat_pfx[pat_len-1]);
        end
        hit_len = LEN_W'(j);
      end
    end
  endfunction

  task automatic send_beat(input logic op, input logic [SYM_W-1:0] sym, input logic restart);
    logic ignored;
    while (idle_en && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    symbol_i   <= sym;
    first_i    <= restart;
    do @(posedge clk_i); while (in_stall_o);
    ignored = (op == OP_PATTERN) && !restart && (pat_len == MAX_PATTERN);
    track_beat(op, sym, restart);
    if (!ignored) beats_sent++;
  endtask

  task automatic test_no_pattern();
    send_beat(OP_TEXT, 8'h00, 1'b1);
    send_beat(OP_TEXT, 8'hFF, 1'b0);
    send_beat(OP_TEXT, 8'hFF, 1'b1);
  endtask

  task automatic test_overlapping_matches();
    send_beat(OP_PATTERN, 8'h00, 1'b1);
    send_beat(OP_PATTERN, 8'h00, 1'b0);
    send_beat(OP_TEXT,    8'h00, 1'b1);
    repeat (3) send_beat(OP_TEXT, 8'h00, 1'b0);
    send_beat(OP_PATTERN, 8'hFF, 1'b1);
    send_beat(OP_TEXT,    8'hFF, 1'b0);
  endtask

  task automatic test_pattern_growth();
    send_beat(OP_PATTERN, 8'h5A, 1'b1);
    send_beat(OP_PATTERN, 8'hA5, 1'b0);
    send_beat(OP_TEXT,    8'h5A, 1'b1);
    send_beat(OP_PATTERN, 8'h3C, 1'b0);
    send_beat(OP_TEXT,    8'hA5, 1'b0);
    send_beat(OP_TEXT,    8'h3C, 1'b0);
  endtask

  task automatic test_pattern_restart();
    send_beat(OP_PATTERN, 8'h11, 1'b1);
    send_beat(OP_PATTERN, 8'h22, 1'b0);
    send_beat(OP_TEXT,    8'h11, 1'b0);
    send_beat(OP_PATTERN, 8'h11, 1'b1);
    send_beat(OP_TEXT,    8'h22, 1'b0);
    send_beat(OP_TEXT,    8'h11, 1'b0);
  endtask

  task automatic test_random_streams();
    logic [SYM_W-1:0] alpha [3];
    int               kinds;
    int               plen;
    int               tlen;
    int               pick;
    logic             text_restart;
    while (beats_sent < BEAT_TARGET) begin
      idle_en <= !(beats_sent >= 600 && beats_sent < 800);
      if ($urandom_range(0, 99) < 75) begin
        foreach (alpha[i]) alpha[i] = SYM_W'($urandom_range(0, 255));
        kinds = $urandom_range(1, 3);
        pick  = $urandom_range(0, 99);
        if (pick < 75)      plen = $urandom_range(1, 5);
        else if (pick < 93) plen = $urandom_range(6, MAX_PATTERN);
        else                plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
        for (int i = 0; i < plen; i++)
          send_beat(OP_PATTERN, alpha[$urandom_range(0, kinds - 1)], i == 0);
        tlen = $urandom_range(8, 40);
        text_restart = 1'($urandom_range(0, 1));
        for (int i = 0; i < tlen; i++) begin
          if (i > 0 && $urandom_range(0, 99) < 5)
            send_beat(OP_PATTERN, alpha[$urandom_range(0, kinds - 1)], 1'b0);
          else
            send_beat(OP_TEXT, alpha[$urandom_range(0, kinds - 1)], i == 0 && text_restart);
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_beat(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                    $urandom_range(0, 99) < 15);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_pattern();
    test_overlapping_matches();
    test_pattern_growth();
    test_pattern_restart();
    test_random_streams();
    in_valid_i <= 1'b0;
    idle_en    <= 1'b1;
    while (match_index_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
